@@ design/pes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pes_pkg;

  localparam int PosW   = 24;
  localparam int QuatW  = 16;
  localparam int GainW  = 16;
  localparam int TimeW  = 32;
  localparam int PosN   = 3;
  localparam int QuatN  = 4;
  localparam int OneQ14 = 16384;

  localparam logic [4:0] STEP_POS_FIRST  = 5'd0;
  localparam logic [4:0] STEP_QUAT_FIRST = 5'd3;
  localparam logic [4:0] STEP_SQ_FIRST   = 5'd7;
  localparam logic [4:0] MULT_LAST       = 5'd11;
  localparam logic [4:0] ROOT_LAST       = 5'd31;
  localparam logic [4:0] DIV_LAST        = 5'd23;
  localparam logic [4:0] QDIV_LAST       = 5'd14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_ROOT,
    ST_DIV,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic       load;
    logic       mult;
    logic       root;
    logic       div;
    logic       commit;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ design/pes_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pes_ctrl
  import pes_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    visible_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 5'd1;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = visible_i ? ST_MULT : ST_WRITE;
        end
      end
      ST_MULT: begin
        if (cnt_q == MULT_LAST) begin
          state_d = ST_ROOT;
          cnt_d   = '0;
        end
      end
      ST_ROOT: begin
        if (cnt_q == ROOT_LAST) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ST_WRITE;
          cnt_d   = '0;
        end
      end
      ST_WRITE: begin
        cnt_d = '0;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.step  = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MULT:  cmd_o.mult = 1'b1;
      ST_ROOT:  cmd_o.root = 1'b1;
      ST_DIV:   cmd_o.div  = 1'b1;
      ST_WRITE: cmd_o.commit = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/pes_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pes_datapath
  import pes_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  output status_t                      status_o,
  input  wire logic                    cfg_valid_i,
  input  wire logic [GainW-1:0]        cfg_data_i,
  input  wire logic                    visible_i,
  input  wire logic [TimeW-1:0]        timestamp_i,
  input  wire logic signed [PosW-1:0]  pos_x_i,
  input  wire logic signed [PosW-1:0]  pos_y_i,
  input  wire logic signed [PosW-1:0]  pos_z_i,
  input  wire logic signed [QuatW-1:0] quat_a_i,
  input  wire logic signed [QuatW-1:0] quat_b_i,
  input  wire logic signed [QuatW-1:0] quat_c_i,
  input  wire logic signed [QuatW-1:0] quat_d_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic                         out_visible_o,
  output logic [TimeW-1:0]             out_timestamp_o,
  output logic signed [PosW-1:0]       filt_x_o,
  output logic signed [PosW-1:0]       filt_y_o,
  output logic signed [PosW-1:0]       filt_z_o,
  output logic signed [QuatW-1:0]      filt_qa_o,
  output logic signed [QuatW-1:0]      filt_qb_o,
  output logic signed [QuatW-1:0]      filt_qc_o,
  output logic signed [QuatW-1:0]      filt_qd_o
);

  logic [GainW-1:0]        gain_q;
  logic signed [PosW-1:0]  s_q [PosN];
  logic signed [QuatW-1:0] q_q [QuatN];

  logic                    vis_q;
  logic [TimeW-1:0]        ts_q;
  logic signed [PosW-1:0]  np_q [PosN];
  logic signed [QuatW-1:0] nq_q [QuatN];

  logic signed [31:0]      opa, opb;
  logic signed [63:0]      prod_q;

  logic [16:0]             prem_q [PosN];
  logic [PosW-1:0]         ppd_q  [PosN];
  logic                    pneg_q [PosN];
  logic [30:0]             m_q    [QuatN];
  logic                    qneg_q [QuatN];
  logic [31:0]             qrem_q [QuatN];
  logic [14:0]             qpd_q  [QuatN];

  logic [63:0]             x_q, res_q, bit_q, root_sum;
  logic [16:0]             den;
  logic [31:0]             root_r;
  logic                    r_zero;

  logic signed [40:0]      pnum;
  logic [40:0]             pabs;
  logic signed [34:0]      qv;
  logic [34:0]             qabs;
  logic [4:0]              idx;

  logic [17:0]             pt    [PosN];
  logic                    pge   [PosN];
  logic [32:0]             qt    [QuatN];
  logic                    qge   [QuatN];
  logic signed [PosW-1:0]  pres  [PosN];
  logic signed [QuatW-1:0] qres  [QuatN];

  logic                    out_valid_q;
  logic                    ov_q;
  logic [TimeW-1:0]        ots_q;
  logic signed [PosW-1:0]  op_q [PosN];
  logic signed [QuatW-1:0] oq_q [QuatN];

  assign den      = 17'd256 + {1'b0, gain_q};
  assign root_r   = res_q[31:0];
  assign r_zero   = (root_r == '0);
  assign root_sum = res_q + bit_q;
  assign idx      = cmd_i.step - 5'd1;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    opa = '0;
    opb = '0;
    if (cmd_i.step < STEP_QUAT_FIRST) begin
      opa = 32'(s_q[cmd_i.step[1:0]]);
      opb = {16'b0, gain_q};
    end else if (cmd_i.step < STEP_SQ_FIRST) begin
      opa = 32'(q_q[2'(cmd_i.step - STEP_QUAT_FIRST)]);
      opb = {16'b0, gain_q};
    end else if (cmd_i.step < MULT_LAST) begin
      opa = {1'b0, m_q[2'(cmd_i.step - STEP_SQ_FIRST)]};
      opb = {1'b0, m_q[2'(cmd_i.step - STEP_SQ_FIRST)]};
    end
  end

  always_comb begin
    pnum = prod_q[40:0] + {{9{np_q[idx[1:0]][PosW-1]}}, np_q[idx[1:0]], 8'b0};
    pabs = pnum[40] ? 41'(-pnum) : 41'(pnum);
    qv   = prod_q[34:0]
         + {{11{nq_q[2'(idx - STEP_QUAT_FIRST)][QuatW-1]}},
            nq_q[2'(idx - STEP_QUAT_FIRST)], 8'b0};
    qabs = qv[34] ? 35'(-qv) : 35'(qv);
  end

  always_comb begin
    for (int i = 0; i < PosN; i++) begin
      pt[i]   = {prem_q[i], ppd_q[i][PosW-1]};
      pge[i]  = (pt[i] >= {1'b0, den});
      pres[i] = pneg_q[i] ? PosW'(-ppd_q[i]) : PosW'(ppd_q[i]);
    end
    for (int j = 0; j < QuatN; j++) begin
      qt[j]  = {qrem_q[j], qpd_q[j][14]};
      qge[j] = (qt[j] >= {1'b0, root_r});
      if (r_zero) begin
        qres[j] = '0;
      end else begin
        qres[j] = qneg_q[j] ? QuatW'(-{1'b0, qpd_q[j]}) : QuatW'({1'b0, qpd_q[j]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PosN; i++) begin
        s_q[i] <= '0;
      end
      for (int j = 0; j < QuatN; j++) begin
        q_q[j] <= (j == QuatN - 1) ? QuatW'(OneQ14) : '0;
      end
    end else begin
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (vis_q) begin
          for (int i = 0; i < PosN; i++) begin
            s_q[i] <= pres[i];
          end
          for (int j = 0; j < QuatN; j++) begin
            q_q[j] <= qres[j];
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vis_q   <= visible_i;
      ts_q    <= timestamp_i;
      np_q[0] <= pos_x_i;
      np_q[1] <= pos_y_i;
      np_q[2] <= pos_z_i;
      nq_q[0] <= quat_a_i;
      nq_q[1] <= quat_b_i;
      nq_q[2] <= quat_c_i;
      nq_q[3] <= quat_d_i;
      x_q     <= '0;
      res_q   <= '0;
      bit_q   <= 64'h4000_0000_0000_0000;
    end

    if (cmd_i.mult) begin
      prod_q <= opa * opb;
      for (int i = 0; i < PosN; i++) begin
        if (cmd_i.step == 5'(i + 1)) begin
          prem_q[i] <= {1'b0, pabs[39:24]};
          ppd_q[i]  <= pabs[23:0];
          pneg_q[i] <= pnum[40];
        end
      end
      for (int j = 0; j < QuatN; j++) begin
        if (cmd_i.step == 5'(j + 1) + STEP_QUAT_FIRST) begin
          m_q[j]    <= qabs[31:1];
          qneg_q[j] <= qv[34];
          qrem_q[j] <= {2'b0, qabs[31:2]};
          qpd_q[j]  <= {qabs[1], 14'b0};
        end
      end
      if (cmd_i.step > STEP_SQ_FIRST) begin
        x_q <= x_q + prod_q;
      end
    end

    if (cmd_i.root) begin
      if (x_q >= root_sum) begin
        x_q   <= x_q - root_sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    if (cmd_i.div) begin
      for (int i = 0; i < PosN; i++) begin
        prem_q[i] <= pge[i] ? 17'(pt[i] - {1'b0, den}) : pt[i][16:0];
        ppd_q[i]  <= {ppd_q[i][PosW-2:0], pge[i]};
      end
      if (cmd_i.step <= QDIV_LAST) begin
        for (int j = 0; j < QuatN; j++) begin
          qrem_q[j] <= qge[j] ? 32'(qt[j] - {1'b0, root_r}) : qt[j][31:0];
          qpd_q[j]  <= {qpd_q[j][13:0], qge[j]};
        end
      end
    end

    if (cmd_i.commit) begin
      ov_q  <= vis_q;
      ots_q <= vis_q ? ts_q : '0;
      for (int i = 0; i < PosN; i++) begin
        op_q[i] <= vis_q ? pres[i] : '0;
      end
      for (int j = 0; j < QuatN; j++) begin
        oq_q[j] <= vis_q ? qres[j] : '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_visible_o   = ov_q;
  assign out_timestamp_o = ots_q;
  assign filt_x_o        = op_q[0];
  assign filt_y_o        = op_q[1];
  assign filt_z_o        = op_q[2];
  assign filt_qa_o       = oq_q[0];
  assign filt_qb_o       = oq_q[1];
  assign filt_qc_o       = oq_q[2];
  assign filt_qd_o       = oq_q[3];

endmodule

`default_nettype wire

@@ design/pose_exponential_smoother.sv @@
// Channel   Handshake                    Payload
// cfg       cfg_valid_i / cfg_ready_o    cfg_data_i (gain k, Q8.8)
// in        in_valid_i  / in_ready_o     visible_i, timestamp_i, pos_*_i, quat_*_i
// out       out_valid_o / out_ready_i    out_visible_o, out_timestamp_o, filt_*_o
//
// A visible item passes in order through the shared 32x32 multiplier, the square root,
// the dividers and the write into the output register. An invisible item goes straight
// to the write. The block returns to idle after each write, so it takes no new item
// until the last one is written, visible or not.
// Reset clears the filter state to zero position and identity orientation.
// A new item is accepted while a result waits; it stalls in its write cycle.
`timescale 1ns / 1ps
`default_nettype none

module pose_exponential_smoother
  import pes_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [GainW-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    visible_i,
  input  wire logic [TimeW-1:0]        timestamp_i,
  input  wire logic signed [PosW-1:0]  pos_x_i,
  input  wire logic signed [PosW-1:0]  pos_y_i,
  input  wire logic signed [PosW-1:0]  pos_z_i,
  input  wire logic signed [QuatW-1:0] quat_a_i,
  input  wire logic signed [QuatW-1:0] quat_b_i,
  input  wire logic signed [QuatW-1:0] quat_c_i,
  input  wire logic signed [QuatW-1:0] quat_d_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         out_visible_o,
  output logic [TimeW-1:0]             out_timestamp_o,
  output logic signed [PosW-1:0]       filt_x_o,
  output logic signed [PosW-1:0]       filt_y_o,
  output logic signed [PosW-1:0]       filt_z_o,
  output logic signed [QuatW-1:0]      filt_qa_o,
  output logic signed [QuatW-1:0]      filt_qb_o,
  output logic signed [QuatW-1:0]      filt_qc_o,
  output logic signed [QuatW-1:0]      filt_qd_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  pes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .visible_i  (visible_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pes_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .visible_i       (visible_i),
    .timestamp_i     (timestamp_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .quat_a_i        (quat_a_i),
    .quat_b_i        (quat_b_i),
    .quat_c_i        (quat_c_i),
    .quat_d_i        (quat_d_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_visible_o   (out_visible_o),
    .out_timestamp_o (out_timestamp_o),
    .filt_x_o        (filt_x_o),
    .filt_y_o        (filt_y_o),
    .filt_z_o        (filt_z_o),
    .filt_qa_o       (filt_qa_o),
    .filt_qb_o       (filt_qb_o),
    .filt_qc_o       (filt_qc_o),
    .filt_qd_o       (filt_qd_o)
  );

endmodule

`default_nettype wire

@@ design/pes_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pes_checker
  import pes_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic                    out_visible_o,
  input wire logic [TimeW-1:0]        out_timestamp_o,
  input wire logic signed [PosW-1:0]  filt_x_o,
  input wire logic signed [QuatW-1:0] filt_qa_o,
  input wire logic signed [QuatW-1:0] filt_qd_o
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_timestamp_o)
      && $stable(filt_x_o))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  // An invisible result carries zero fields.
  a_invis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_visible_o |-> out_timestamp_o == '0 && filt_x_o == '0
      && filt_qa_o == '0 && filt_qd_o == '0)
    else $error("invisible result not zeroed");

  // The first and last normalized components never exceed unit length.
  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> filt_qa_o <= 16'sd16384 && filt_qa_o >= -16'sd16384
      && filt_qd_o <= 16'sd16384 && filt_qd_o >= -16'sd16384)
    else $error("quaternion component out of range");

endmodule

bind pose_exponential_smoother pes_checker u_pes_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_visible_o   (out_visible_o),
  .out_timestamp_o (out_timestamp_o),
  .filt_x_o        (filt_x_o),
  .filt_qa_o       (filt_qa_o),
  .filt_qd_o       (filt_qd_o)
);

`default_nettype wire
